// ===== design/cda_pkg.sv =====
// Shared types, codes and calendar helpers for the calendar date adjust block.
// Used by cda_ctrl, cda_datapath and calendar_date_adjust_core.
package cda_pkg;

  localparam logic [2:0] KIND_SET_YEAR   = 3'd0;
  localparam logic [2:0] KIND_SET_MONTH  = 3'd1;
  localparam logic [2:0] KIND_SET_DAY    = 3'd2;
  localparam logic [2:0] KIND_ADD_YEARS  = 3'd3;
  localparam logic [2:0] KIND_ADD_MONTHS = 3'd4;
  localparam logic [2:0] KIND_ADD_DAYS   = 3'd5;

  localparam logic [11:0] YEAR_MIN      = 12'd1900;
  localparam logic [11:0] YEAR_MAX      = 12'd2100;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;
  localparam logic [4:0]  LEAP_FEB_DAYS = 5'd29;

  // Reciprocal of three scaled by 2**17, exact for dividends below 2**17.
  localparam logic [16:0] RECIP_THREE = 17'd43691;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic mdiv;
    logic mapply;
    logic walk;
    logic load_out;
  } cda_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       acc_low;
    logic       walk_fit;
  } cda_status_t;

  // The held year never leaves 1900..2100, where 2000 is the only century leap year.
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != YEAR_MIN) && (y != YEAR_MAX);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

  function automatic logic [4:0] fix_day(input logic signed [16:0] dy,
                                         input logic [3:0] m, input logic leap);
    logic [4:0] len;
    logic [4:0] res;
    len = month_days(m, 1'b0);
    if (dy < 17'sd1) begin
      res = 5'd1;
    end else if (m != MONTH_FEB) begin
      res = (dy <= $signed({12'd0, len})) ? dy[4:0] : 5'd1;
    end else if (dy < 17'sd29) begin
      res = dy[4:0];
    end else begin
      res = leap ? LEAP_FEB_DAYS : 5'd1;
    end
    return res;
  endfunction

endpackage

// ===== design/cda_ctrl.sv =====
// Controller state machine for the calendar date adjust block.
// Sequences the datapath through cda_cmd_t commands; depends on cda_pkg.
module cda_ctrl import cda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  cda_status_t status,
  output cda_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MDIV   = 6'b000100,
    S_MAPPLY = 6'b001000,
    S_DWALK  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (status.kind)
          KIND_ADD_MONTHS: state_next = S_MDIV;
          KIND_ADD_DAYS:   state_next = S_DWALK;
          default:         state_next = S_OUT;
        endcase
      end
      S_MDIV: begin
        cmd.mdiv   = 1'b1;
        state_next = S_MAPPLY;
      end
      S_MAPPLY: begin
        cmd.mapply = 1'b1;
        state_next = S_OUT;
      end
      S_DWALK: begin
        cmd.walk = 1'b1;
        if (status.acc_low || status.walk_fit) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECODE))
    else $error("Accepted transfer did not move the controller to decode.");

  a_walk_continues: assert property (@(posedge clk) disable iff (rst)
    (state == S_DWALK && !status.acc_low && !status.walk_fit) |=> (state == S_DWALK))
    else $error("Day walk ended before the remaining days fit the month.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.load_out)
    else $error("Result register reloaded while a transfer was pending.");

endmodule

// ===== design/cda_datapath.sv =====
// Datapath for the calendar date adjust block: date registers, month carry
// divider and day walk. Controlled by cda_ctrl; depends on cda_pkg.
module cda_datapath import cda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cda_cmd_t           cmd,
  output cda_status_t        status,
  input  logic [2:0]         kind,
  input  logic signed [15:0] value,
  output logic [4:0]         day_now,
  output logic [3:0]         month_now,
  output logic [11:0]        year_now
);

  logic [2:0]         kind_r;
  logic signed [15:0] value_r;
  logic signed [16:0] acc;
  logic [11:0]        quo;
  logic [4:0]         day;
  logic [3:0]         month;
  logic [11:0]        year;

  logic               leap_cur;
  logic [4:0]         len_cur;
  logic signed [16:0] value_ext;
  logic signed [16:0] day_ext;
  logic signed [16:0] year_sum;
  logic [11:0]        set_year;
  logic [11:0]        add_year;
  logic [3:0]         set_month;
  logic signed [16:0] acc_base;
  logic signed [16:0] m1;
  logic [29:0]        quo_prod;
  logic [14:0]        rem;
  logic [12:0]        carry_year;
  logic [11:0]        yc;
  logic [4:0]         dmid;
  logic [3:0]         mnew;
  logic [4:0]         dcar;
  logic               acc_over;

  assign leap_cur  = is_leap(year);
  assign len_cur   = month_days(month, leap_cur);
  assign value_ext = {value_r[15], value_r};
  assign day_ext   = $signed({12'd0, day});
  assign year_sum  = $signed({5'd0, year}) + value_ext;

  assign set_year  = (value_r >= 16'sd1900 && value_r <= 16'sd2100) ? value_r[11:0] : YEAR_MIN;
  assign add_year  = (year_sum >= 17'sd1900 && year_sum <= 17'sd2100) ? year_sum[11:0] : year;
  assign set_month = (value_r >= 16'sd1 && value_r <= 16'sd12) ? value_r[3:0] : 4'd1;
  assign acc_base  = (kind_r == KIND_ADD_DAYS) ? $signed({12'd0, day}) : $signed({13'd0, month});

  // Month sum minus one, divided by twelve as a shift by two and a division by three.
  assign m1       = acc - 17'sd1;
  assign quo_prod = 30'(m1[15:2]) * 30'(RECIP_THREE);
  assign rem      = m1[14:0] - {quo, 3'b000} - 15'({quo, 2'b00});

  assign carry_year = 13'(year) + 13'(quo);
  assign yc         = (carry_year <= 13'(YEAR_MAX)) ? carry_year[11:0] : year;
  assign dmid       = fix_day(day_ext, month, is_leap(yc));
  assign mnew       = rem[3:0] + 4'd1;
  assign dcar       = fix_day($signed({12'd0, dmid}), mnew, is_leap(yc));
  assign acc_over   = (acc > 17'sd12);

  assign status.kind     = kind_r;
  assign status.acc_low  = (acc < 17'sd1);
  assign status.walk_fit = (acc <= $signed({12'd0, len_cur}));

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= 5'd1;
      month <= 4'd1;
      year  <= YEAR_MIN;
    end else begin
      if (cmd.decode) begin
        case (kind_r)
          KIND_SET_YEAR: begin
            year <= set_year;
            day  <= fix_day(day_ext, month, is_leap(set_year));
          end
          KIND_SET_MONTH: begin
            month <= set_month;
            day   <= fix_day(day_ext, set_month, leap_cur);
          end
          KIND_SET_DAY: begin
            day <= fix_day(value_ext, month, leap_cur);
          end
          KIND_ADD_YEARS: begin
            year <= add_year;
            day  <= fix_day(day_ext, month, is_leap(add_year));
          end
          default: begin
          end
        endcase
      end
      if (cmd.mapply && !status.acc_low) begin
        if (acc_over) begin
          year  <= yc;
          month <= mnew;
          day   <= dcar;
        end else begin
          month <= acc[3:0];
          day   <= fix_day(day_ext, acc[3:0], leap_cur);
        end
      end
      if (cmd.walk && !status.acc_low) begin
        if (status.walk_fit) begin
          day <= acc[4:0];
        end else if (month == MONTH_DEC) begin
          month <= 4'd1;
          if (year != YEAR_MAX) begin
            year <= year + 12'd1;
          end
        end else begin
          month <= month + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= kind;
      value_r <= value;
    end
    if (cmd.decode) begin
      acc <= acc_base + value_ext;
    end
    if (cmd.mdiv) begin
      quo <= quo_prod[28:17];
    end
    if (cmd.walk && !status.acc_low && !status.walk_fit) begin
      acc <= acc - $signed({12'd0, len_cur});
    end
    if (cmd.load_out) begin
      day_now   <= day;
      month_now <= month;
      year_now  <= year;
    end
  end

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (month >= 4'd1 && month <= MONTH_DEC))
    else $error("Held month left the range of January to December.");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (year >= YEAR_MIN && year <= YEAR_MAX))
    else $error("Held year left the supported range.");

  a_day_fits: assert property (@(posedge clk) disable iff (rst)
    !cmd.walk |-> (day >= 5'd1 && day <= len_cur))
    else $error("Held day does not fit the held month.");

endmodule

// ===== design/calendar_date_adjust_core.sv =====
// Top level of the calendar date adjust block: controller plus datapath.
// Depends on cda_pkg, cda_ctrl and cda_datapath.
//
// The block holds one Gregorian date in 1900..2100. Each command on the input
// channel (kind, value) sets the year, month or day, or adds a signed count of
// years, months or days; every command yields one transfer on the output
// channel carrying the resulting day_now, month_now and year_now.
// Both channels use valid and ready. One command is worked on at a time, and
// in_ready is high only while the controller waits for a new command.
// Set and add-year commands and unused kinds pass from acceptance through the
// decode state to the output state; adding months also passes through the
// two-step month carry divider. Adding days walks one month per cycle through
// the day walk loop. The next command is accepted in the cycle after a result
// is loaded, as the controller then returns to waiting for a command.
// The result sits in an output register, so a stalled receiver holds only
// the finished result; the block takes the next command meanwhile, and waits
// before loading its own result until the register is free.
// Synchronous reset sets the date to January 1, 1900 and empties the output.
module calendar_date_adjust_core import cda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         day_now,
  output logic [3:0]         month_now,
  output logic [11:0]        year_now
);

  cda_cmd_t    cmd;
  cda_status_t status;

  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cda_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .kind      (kind),
    .value     (value),
    .day_now   (day_now),
    .month_now (month_now),
    .year_now  (year_now)
  );

endmodule
